// File: sv/tcsl_pkg.sv
// ----------------------------------------------------------------------------
// tcsl_pkg
// Types and constants shared by the ClientHello server-name locator.
// ----------------------------------------------------------------------------
package tcsl_pkg;

    localparam int unsigned CNT_W = 17;
    localparam int unsigned POS_W = 18;

    localparam logic [CNT_W-1:0] HDR_LEN = 17'd43;

    localparam logic [7:0] CONTENT_HANDSHAKE = 8'h16;
    localparam logic [7:0] VERSION_MAJOR     = 8'h03;
    localparam logic [7:0] HS_CLIENT_HELLO   = 8'h01;
    localparam logic [7:0] NAME_TYPE_HOST    = 8'h00;
    localparam logic [15:0] EXT_SERVER_NAME  = 16'h0000;

    localparam logic [CNT_W-1:0] OFS_CONTENT = 17'd0;
    localparam logic [CNT_W-1:0] OFS_VERSION = 17'd1;
    localparam logic [CNT_W-1:0] OFS_HS_TYPE = 17'd5;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_NOT_HS   = 3'd2;
    localparam logic [2:0] ST_NOT_CH   = 3'd3;
    localparam logic [2:0] ST_NO_SNI   = 3'd4;
    localparam logic [2:0] ST_BAD_SNI  = 3'd5;
    localparam logic [2:0] ST_TOO_LONG = 3'd6;

    typedef enum logic [13:0] {
        PH_HEADER  = 14'h0001,
        PH_CS_HI   = 14'h0002,
        PH_CS_LO   = 14'h0004,
        PH_CM      = 14'h0008,
        PH_EX_HI   = 14'h0010,
        PH_EX_LO   = 14'h0020,
        PH_ET_HI   = 14'h0040,
        PH_ET_LO   = 14'h0080,
        PH_EL_HI   = 14'h0100,
        PH_EL_LO   = 14'h0200,
        PH_SN_TYPE = 14'h0400,
        PH_SN_HI   = 14'h0800,
        PH_SN_LO   = 14'h1000,
        PH_DONE    = 14'h2000
    } phase_t;

    typedef struct packed {
        logic [15:0] split_offset;
        logic [15:0] name_length;
        logic [15:0] name_start;
        logic [2:0]  status;
    } result_t;

endpackage

// File: sv/tcsl_parser.sv
// ----------------------------------------------------------------------------
// tcsl_parser
// Per-byte ClientHello walker: parse state and the verdict for the payload.
// ----------------------------------------------------------------------------
module tcsl_parser
    import tcsl_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 65535
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output result_t       result
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] next_pos_reg, next_pos_next;
    logic [POS_W-1:0] ext_end_reg, ext_end_next;
    logic [7:0]       held_reg, held_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      length_reg, length_next;
    logic [2:0]       verdict_reg, verdict_next;
    logic             fixed_reg, fixed_next;

    logic [POS_W-1:0] ofs;
    logic [POS_W-1:0] ofs_plus1;
    logic [15:0]      word;
    logic [POS_W:0]   ext_hdr_end;
    logic [POS_W:0]   sn_body_end;
    logic [CNT_W-1:0] name_end;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        phase_next      = phase_reg;
        next_pos_next   = next_pos_reg;
        ext_end_next    = ext_end_reg;
        held_next       = held_reg;
        start_next      = start_reg;
        length_next     = length_reg;
        verdict_next    = verdict_reg;
        fixed_next      = fixed_reg;

        ofs         = {1'b0, byte_count_reg};
        ofs_plus1   = ofs + POS_W'(1);
        word        = {held_reg, data_byte};
        ext_hdr_end = '0;
        sn_body_end = {1'b0, ofs} + (POS_W+1)'(8);

        if (byte_count_reg < MAX_CNT)
        begin
            if (!fixed_reg)
            begin
                if ((byte_count_reg == OFS_CONTENT && data_byte != CONTENT_HANDSHAKE) ||
                    (byte_count_reg == OFS_VERSION && data_byte != VERSION_MAJOR))
                begin
                    verdict_next = ST_NOT_HS;
                    fixed_next   = 1'b1;
                    phase_next   = PH_DONE;
                end
                else if (byte_count_reg == OFS_HS_TYPE && data_byte != HS_CLIENT_HELLO)
                begin
                    verdict_next = ST_NOT_CH;
                    fixed_next   = 1'b1;
                    phase_next   = PH_DONE;
                end
            end

            if (phase_next != PH_DONE && ofs == next_pos_reg)
            begin
                case (phase_next)
                    PH_HEADER:
                    begin
                        next_pos_next = ofs_plus1 + POS_W'(data_byte);
                        phase_next    = PH_CS_HI;
                    end
                    PH_CS_HI:
                    begin
                        held_next     = data_byte;
                        next_pos_next = ofs_plus1;
                        phase_next    = PH_CS_LO;
                    end
                    PH_CS_LO:
                    begin
                        next_pos_next = ofs_plus1 + POS_W'(word);
                        phase_next    = PH_CM;
                    end
                    PH_CM:
                    begin
                        next_pos_next = ofs_plus1 + POS_W'(data_byte);
                        phase_next    = PH_EX_HI;
                    end
                    PH_EX_HI:
                    begin
                        held_next     = data_byte;
                        next_pos_next = ofs_plus1;
                        phase_next    = PH_EX_LO;
                    end
                    PH_EX_LO:
                    begin
                        next_pos_next = ofs_plus1;
                        ext_end_next  = ofs_plus1 + POS_W'(word);
                        ext_hdr_end   = {1'b0, ofs_plus1} + (POS_W+1)'(4);
                        if (ext_hdr_end > {1'b0, ext_end_next})
                            phase_next = PH_DONE;
                        else
                            phase_next = PH_ET_HI;
                    end
                    PH_ET_HI:
                    begin
                        held_next     = data_byte;
                        next_pos_next = ofs_plus1;
                        phase_next    = PH_ET_LO;
                    end
                    PH_ET_LO:
                    begin
                        if (word == EXT_SERVER_NAME)
                        begin
                            verdict_next = ST_BAD_SNI;
                            if (sn_body_end > {1'b0, ext_end_reg})
                            begin
                                fixed_next = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                next_pos_next = ofs + POS_W'(5);
                                phase_next    = PH_SN_TYPE;
                            end
                        end
                        else
                        begin
                            next_pos_next = ofs_plus1;
                            phase_next    = PH_EL_HI;
                        end
                    end
                    PH_EL_HI:
                    begin
                        held_next     = data_byte;
                        next_pos_next = ofs_plus1;
                        phase_next    = PH_EL_LO;
                    end
                    PH_EL_LO:
                    begin
                        next_pos_next = ofs_plus1 + POS_W'(word);
                        ext_hdr_end   = {1'b0, next_pos_next} + (POS_W+1)'(4);
                        if (ext_hdr_end > {1'b0, ext_end_reg})
                            phase_next = PH_DONE;
                        else
                            phase_next = PH_ET_HI;
                    end
                    PH_SN_TYPE:
                    begin
                        if (data_byte != NAME_TYPE_HOST)
                        begin
                            verdict_next = ST_BAD_SNI;
                            fixed_next   = 1'b1;
                            phase_next   = PH_DONE;
                        end
                        else
                        begin
                            next_pos_next = ofs_plus1;
                            phase_next    = PH_SN_HI;
                        end
                    end
                    PH_SN_HI:
                    begin
                        held_next     = data_byte;
                        next_pos_next = ofs_plus1;
                        phase_next    = PH_SN_LO;
                    end
                    PH_SN_LO:
                    begin
                        start_next   = ofs_plus1[15:0];
                        length_next  = word;
                        verdict_next = ST_FOUND;
                        phase_next   = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end

        if (byte_count_reg <= MAX_CNT)
            byte_count_next = byte_count_reg + CNT_W'(1);
    end

    // final verdict, taken from the state after this byte
    always_comb
    begin
        name_end = CNT_W'({1'b0, start_next}) + CNT_W'({1'b0, length_next});
        result   = '0;
        if (byte_count_next > MAX_CNT)
            result.status = ST_TOO_LONG;
        else if (byte_count_next < HDR_LEN)
            result.status = ST_SHORT;
        else if (verdict_next == ST_FOUND)
        begin
            if (name_end <= byte_count_next)
            begin
                result.status       = ST_FOUND;
                result.name_start   = start_next;
                result.name_length  = length_next;
                result.split_offset = start_next + {1'b0, length_next[15:1]};
            end
            else
                result.status = ST_BAD_SNI;
        end
        else
            result.status = verdict_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            phase_reg      <= PH_HEADER;
            next_pos_reg   <= POS_W'(HDR_LEN);
            ext_end_reg    <= '0;
            held_reg       <= '0;
            start_reg      <= '0;
            length_reg     <= '0;
            verdict_reg    <= ST_NO_SNI;
            fixed_reg      <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                byte_count_reg <= '0;
                phase_reg      <= PH_HEADER;
                next_pos_reg   <= POS_W'(HDR_LEN);
                ext_end_reg    <= '0;
                held_reg       <= '0;
                start_reg      <= '0;
                length_reg     <= '0;
                verdict_reg    <= ST_NO_SNI;
                fixed_reg      <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                phase_reg      <= phase_next;
                next_pos_reg   <= next_pos_next;
                ext_end_reg    <= ext_end_next;
                held_reg       <= held_next;
                start_reg      <= start_next;
                length_reg     <= length_next;
                verdict_reg    <= verdict_next;
                fixed_reg      <= fixed_next;
            end
        end
    end

endmodule

// File: sv/tls_client_hello_sni_locator.sv
// Path: a payload's final byte goes through the input register and then the result
// register before its result is shown on m_tvalid.
// Throughput: one byte per cycle; bytes that are not final move on while a result
// waits on m_tready, a final byte stalls in the input register until that frees.
// Reset: rst_n asynchronous, active low; the parser returns to the record header,
// and both registers empty. State also clears after each final byte.
// ----------------------------------------------------------------------------
// tls_client_hello_sni_locator
// Locates the server name in a TLS ClientHello carried one payload byte per transfer.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_locator
    import tcsl_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [2:0] status, [18:3] name_start,
                                   // [34:19] name_length, [50:35] split_offset
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       advance;

    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result;

    // bytes that are not final never wait on the result register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tcsl_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg};

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the ClientHello server-name locator. Streams whole TCP payloads
// one byte per transfer: directed header, length and server-name cases,
// randomized well-formed hellos with damage, noise and backpressure bursts.
// A local parser model predicts each result.
// ----------------------------------------------------------------------------
module tb_top;
    import tcsl_pkg::*;

    localparam int unsigned MAX_BYTES   = 65535;
    localparam logic [15:0] EXT_PADDING = 16'h0015;

    typedef enum int {SNI_NONE, SNI_GOOD, SNI_BAD_TYPE, SNI_STUNTED} sni_shape_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    tls_client_hello_sni_locator #(.MAX_PAYLOAD(MAX_BYTES)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // parser model state
    logic [CNT_W-1:0] seen_cnt;
    phase_t           walk_phase;
    logic [POS_W-1:0] want_pos;
    logic [POS_W-1:0] ext_limit;
    logic [7:0]       hi_byte;
    logic [15:0]      sni_start;
    logic [15:0]      sni_len;
    logic [2:0]       answer;
    logic             answer_locked;

    result_t     locate_q[$];
    logic [7:0]  pkt[$];
    int unsigned ext_len_at;

    int src_gap_pct;
    int sink_stall_pct;
    int hold_cycles;
    int errors;
    int bytes_sent;
    int payloads_sent;
    int results_seen;
    int longest_pkt;
    int status_seen[7];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void clear_walker();
        seen_cnt      = '0;
        walk_phase    = PH_HEADER;
        want_pos      = POS_W'(HDR_LEN);
        ext_limit     = '0;
        hi_byte       = '0;
        sni_start     = '0;
        sni_len       = '0;
        answer        = ST_NO_SNI;
        answer_locked = 1'b0;
    endfunction

    function automatic void lock_answer(logic [2:0] v);
        answer        = v;
        answer_locked = 1'b1;
        walk_phase    = PH_DONE;
    endfunction

    function automatic void open_ext_header();
        if (32'(want_pos) + 4 > 32'(ext_limit))
            walk_phase = PH_DONE;
        else
            walk_phase = PH_ET_HI;
    endfunction

    // Advances the model by one byte; returns 1 with the result on the final byte.
    function automatic bit track_byte(input logic [7:0] b, input bit last, output result_t r);
        int unsigned p;
        int unsigned v;
        p = 32'(seen_cnt);
        v = 32'({hi_byte, b});
        r = '0;
        if (p < MAX_BYTES)
        begin
            if (!answer_locked)
            begin
                if ((p == 32'(OFS_CONTENT) && b != CONTENT_HANDSHAKE) ||
                    (p == 32'(OFS_VERSION) && b != VERSION_MAJOR))
                    lock_answer(ST_NOT_HS);
                else if (p == 32'(OFS_HS_TYPE) && b != HS_CLIENT_HELLO)
                    lock_answer(ST_NOT_CH);
            end
            if (walk_phase != PH_DONE && p == 32'(want_pos))
            begin
                case (walk_phase)
                    PH_HEADER:
                    begin
                        want_pos   = POS_W'(p + 1 + 32'(b));
                        walk_phase = PH_CS_HI;
                    end
                    PH_CS_HI, PH_EX_HI, PH_ET_HI, PH_EL_HI, PH_SN_HI:
                    begin
                        hi_byte  = b;
                        want_pos = POS_W'(p + 1);
                        case (walk_phase)
                            PH_CS_HI: walk_phase = PH_CS_LO;
                            PH_EX_HI: walk_phase = PH_EX_LO;
                            PH_ET_HI: walk_phase = PH_ET_LO;
                            PH_EL_HI: walk_phase = PH_EL_LO;
                            default:  walk_phase = PH_SN_LO;
                        endcase
                    end
                    PH_CS_LO:
                    begin
                        want_pos   = POS_W'(p + 1 + v);
                        walk_phase = PH_CM;
                    end
                    PH_CM:
                    begin
                        want_pos   = POS_W'(p + 1 + 32'(b));
                        walk_phase = PH_EX_HI;
                    end
                    PH_EX_LO:
                    begin
                        want_pos  = POS_W'(p + 1);
                        ext_limit = POS_W'(p + 1 + v);
                        open_ext_header();
                    end
                    PH_ET_LO:
                    begin
                        if (v == 32'(EXT_SERVER_NAME))
                        begin
                            // name list starts after the 2-byte extension length
                            if (p + 8 > 32'(ext_limit))
                                lock_answer(ST_BAD_SNI);
                            else
                            begin
                                answer     = ST_BAD_SNI;
                                want_pos   = POS_W'(p + 5);
                                walk_phase = PH_SN_TYPE;
                            end
                        end
                        else
                        begin
                            want_pos   = POS_W'(p + 1);
                            walk_phase = PH_EL_HI;
                        end
                    end
                    PH_EL_LO:
                    begin
                        want_pos = POS_W'(p + 1 + v);
                        open_ext_header();
                    end
                    PH_SN_TYPE:
                    begin
                        if (b != NAME_TYPE_HOST)
                            lock_answer(ST_BAD_SNI);
                        else
                        begin
                            want_pos   = POS_W'(p + 1);
                            walk_phase = PH_SN_HI;
                        end
                    end
                    PH_SN_LO:
                    begin
                        sni_start  = 16'(p + 1);
                        sni_len    = 16'(v);
                        answer     = ST_FOUND;
                        walk_phase = PH_DONE;
                    end
                    default: walk_phase = PH_DONE;
                endcase
            end
        end
        if (32'(seen_cnt) <= MAX_BYTES)
            seen_cnt = seen_cnt + CNT_W'(1);
        if (!last)
            return 1'b0;
        if (32'(seen_cnt) > MAX_BYTES)
            r.status = ST_TOO_LONG;
        else if (seen_cnt < HDR_LEN)
            r.status = ST_SHORT;
        else if (answer == ST_FOUND)
        begin
            if (int'(sni_start) + int'(sni_len) <= int'(seen_cnt))
            begin
                r.status       = ST_FOUND;
                r.name_start   = sni_start;
                r.name_length  = sni_len;
                r.split_offset = sni_start + (sni_len >> 1);
            end
            else
                r.status = ST_BAD_SNI;
        end
        else
            r.status = answer;
        clear_walker();
        return 1'b1;
    endfunction

    function automatic void put16(logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put_random(int unsigned n);
        repeat (n) pkt.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void trim_pkt(int unsigned keep);
        while (pkt.size() > keep)
            pkt.delete(pkt.size() - 1);
    endfunction

    function automatic void add_filler_ext();
        int unsigned len;
        len = $urandom_range(12);
        if ($urandom_range(15) == 0)
            put16(EXT_SERVER_NAME);
        else if ($urandom_range(1) == 1)
            put16(16'($urandom_range(1, 48)));
        else
            put16(16'($urandom_range(1, 16'hFFFF)));
        put16(16'(len));
        put_random(len);
    endfunction

    function automatic void build_hello(input int unsigned sid_len, cs_len, cm_len, pre_n,
                                        pad_len, input sni_shape_t shape,
                                        input int unsigned name_len, post_n);
        int unsigned body;
        int unsigned tail_n;
        tail_n = post_n;
        pkt.delete();
        pkt.push_back(CONTENT_HANDSHAKE);
        pkt.push_back(VERSION_MAJOR);
        put_random(3);
        pkt.push_back(HS_CLIENT_HELLO);
        put_random(32'(HDR_LEN) - 6);
        pkt.push_back(8'(sid_len));
        put_random(sid_len);
        put16(16'(cs_len));
        put_random(cs_len);
        pkt.push_back(8'(cm_len));
        put_random(cm_len);
        ext_len_at = pkt.size();
        put16(16'h0000);
        repeat (pre_n) add_filler_ext();
        if (pad_len != 0)
        begin
            put16(EXT_PADDING);
            put16(16'(pad_len));
            repeat (pad_len) pkt.push_back(8'h00);
        end
        case (shape)
            SNI_GOOD, SNI_BAD_TYPE:
            begin
                put16(EXT_SERVER_NAME);
                put16(16'(name_len + 5));
                put16(16'(name_len + 3));
                pkt.push_back(shape == SNI_GOOD ? NAME_TYPE_HOST
                                                : 8'($urandom_range(1, 255)));
                put16(16'(name_len));
                put_random(name_len);
            end
            SNI_STUNTED:
            begin
                // body too short for list length, name type and name length
                body = $urandom_range(4);
                put16(EXT_SERVER_NAME);
                put16(16'(body));
                put_random(body);
                tail_n = 0;
            end
            default: ;
        endcase
        repeat (tail_n) add_filler_ext();
        body = pkt.size() - ext_len_at - 2;
        pkt[ext_len_at]     = body[15:8];
        pkt[ext_len_at + 1] = body[7:0];
    endfunction

    function automatic void flag_error(string what);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", what);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last);
        result_t r;
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if (track_byte(b, last, r))
            locate_q.push_back(r);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_payload();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
        payloads_sent++;
        if (pkt.size() > longest_pkt)
            longest_pkt = pkt.size();
    endtask

    task automatic wait_drained();
        while (locate_q.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // receiver side
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else
                m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result checker
    initial
    begin
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[50:0]);
                results_seen++;
                if (got.status < 7)
                    status_seen[got.status]++;
                if (locate_q.size() == 0)
                    flag_error($sformatf("unexpected result, status %0d start %0d len %0d",
                                         got.status, got.name_start, got.name_length));
                else
                begin
                    want = locate_q.pop_front();
                    if (got.status !== want.status || got.name_start !== want.name_start ||
                        got.name_length !== want.name_length ||
                        got.split_offset !== want.split_offset)
                        flag_error($sformatf(
                            "result %0d exp st %0d start %0d len %0d split %0d, got %0d %0d %0d %0d",
                            results_seen, want.status, want.name_start, want.name_length,
                            want.split_offset, got.status, got.name_start, got.name_length,
                            got.split_offset));
                end
            end
        end
    end

    task automatic test_short_payloads();
        pkt.delete();
        pkt.push_back(CONTENT_HANDSHAKE);
        send_payload();
        build_hello(0, 2, 1, 0, 0, SNI_GOOD, 8, 0);
        trim_pkt(32'(HDR_LEN) - 1);
        send_payload();
        build_hello(0, 2, 1, 0, 0, SNI_GOOD, 8, 0);
        trim_pkt(32'(HDR_LEN));
        send_payload();
        pkt.delete();
        repeat (20) pkt.push_back(8'hFF);
        send_payload();
    endtask

    task automatic test_header_checks();
        build_hello(4, 4, 1, 1, 0, SNI_GOOD, 10, 0);
        pkt[OFS_CONTENT] = 8'h17;
        send_payload();
        build_hello(4, 4, 1, 1, 0, SNI_GOOD, 10, 0);
        pkt[OFS_VERSION] = 8'h02;
        send_payload();
        build_hello(4, 4, 1, 1, 0, SNI_GOOD, 10, 0);
        pkt[OFS_HS_TYPE] = 8'h02;
        send_payload();
        build_hello(4, 4, 1, 1, 0, SNI_GOOD, 10, 0);
        pkt[OFS_CONTENT] = 8'h00;
        pkt[OFS_HS_TYPE] = 8'h00;
        send_payload();
    endtask

    task automatic test_server_name();
        int unsigned keep;
        build_hello(32, 6, 1, 0, 0, SNI_GOOD, 15, 0);
        send_payload();
        build_hello(0, 0, 0, 0, 0, SNI_GOOD, 0, 2);
        send_payload();
        build_hello(8, 4, 2, 3, 0, SNI_GOOD, 31, 2);
        send_payload();
        build_hello(8, 4, 2, 3, 0, SNI_NONE, 0, 0);
        send_payload();
        build_hello(2, 2, 1, 1, 0, SNI_BAD_TYPE, 6, 1);
        send_payload();
        build_hello(2, 2, 1, 1, 0, SNI_STUNTED, 0, 0);
        send_payload();
        // name cut off by the end of the payload
        build_hello(0, 2, 1, 0, 0, SNI_GOOD, 12, 0);
        trim_pkt(pkt.size() - 3);
        send_payload();
        // payload ends inside the cipher suites
        build_hello(0, 40, 1, 0, 0, SNI_GOOD, 12, 0);
        trim_pkt(60);
        send_payload();
        // extensions length overstates the payload
        build_hello(0, 2, 1, 1, 0, SNI_GOOD, 9, 0);
        pkt[ext_len_at] = 8'hFF;
        send_payload();
        // extensions length stops before the server name
        build_hello(0, 2, 1, 1, 0, SNI_GOOD, 9, 0);
        keep = pkt.size() - ext_len_at - 2 - 14;
        pkt[ext_len_at]     = 8'(keep >> 8);
        pkt[ext_len_at + 1] = 8'(keep);
        send_payload();
    endtask

    task automatic make_random_payload();
        int pick;
        int unsigned idx;
        sni_shape_t shape;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            pkt.delete();
            put_random($urandom_range(1, 60));
            if ($urandom_range(1) == 1)
                pkt[0] = CONTENT_HANDSHAKE;
            if (pkt.size() > 1 && $urandom_range(1) == 1)
                pkt[1] = VERSION_MAJOR;
            if (pkt.size() > 5 && $urandom_range(1) == 1)
                pkt[5] = HS_CLIENT_HELLO;
            return;
        end
        pick = $urandom_range(99);
        shape = pick < 70 ? SNI_GOOD : pick < 80 ? SNI_NONE :
                pick < 90 ? SNI_BAD_TYPE : SNI_STUNTED;
        build_hello($urandom_range(3) == 0 ? $urandom_range(32) : $urandom_range(4),
                    $urandom_range(12), $urandom_range(3), $urandom_range(3), 0, shape,
                    $urandom_range(9) == 0 ? $urandom_range(300) : $urandom_range(24),
                    $urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            idx = $urandom_range(1, pkt.size());
            trim_pkt(idx);
        end
        else if (pick < 20)
            pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom_range(255));
        else if (pick < 26)
        begin
            idx = $urandom_range(2);
            idx = idx == 0 ? 32'(OFS_CONTENT) : idx == 1 ? 32'(OFS_VERSION)
                                                         : 32'(OFS_HS_TYPE);
            pkt[idx] = 8'($urandom_range(255));
        end
        else if (pick < 32)
        begin
            pkt[ext_len_at]     = 8'($urandom_range(255));
            pkt[ext_len_at + 1] = 8'($urandom_range(255));
        end
        else if (pick < 36)
            put_random($urandom_range(1, 10));
    endtask

    task automatic test_random_traffic(int byte_goal, int payload_goal);
        int b0;
        int p0;
        b0 = bytes_sent;
        p0 = payloads_sent;
        while (bytes_sent - b0 < byte_goal || payloads_sent - p0 < payload_goal)
        begin
            make_random_payload();
            send_payload();
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(posedge clk);
        hold_cycles = 300;
        @(negedge clk);
        repeat (40)
        begin
            pkt.delete();
            put_random($urandom_range(1, 4));
            send_payload();
        end
        wait_drained();
        @(posedge clk);
        hold_cycles = 120;
        @(negedge clk);
        repeat (3)
        begin
            build_hello(0, 2, 1, 0, 0, SNI_GOOD, 3, 0);
            send_payload();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        hold_cycles    = 0;
        src_gap_pct    = 27;
        sink_stall_pct = 49;
        clear_walker();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_short_payloads();
        test_header_checks();
        test_server_name();
        test_random_traffic(100, 2);

        src_gap_pct    = 49;
        sink_stall_pct = 27;
        test_random_traffic(100, 2);
        test_backpressure();

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_traffic(100, 2);

        wait_drained();
        repeat (10) @(negedge clk);
        if (locate_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", locate_q.size()));
        $display("covered %0d payloads in %0d byte transfers, longest %0d bytes, %0d results",
                 payloads_sent, bytes_sent, longest_pkt, results_seen);
        $display("statuses: found %0d short %0d not_hs %0d not_ch %0d no_sni %0d bad %0d long %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: tls_client_hello_sni_locator.f
sv/tcsl_pkg.sv
sv/tcsl_parser.sv
sv/tls_client_hello_sni_locator.sv
bench/tb_top.sv
